// ===== hdl/sorted_deadline_event_queue_defines.svh =====
// Assertion macros for the checker file of the event queue.
`ifndef SORTED_DEADLINE_EVENT_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_EVENT_QUEUE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define SDEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SDEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sdeq_pkg.sv =====
`default_nettype none
package sdeq_pkg;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_ADDED = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_IDLE  = 2'd2;
    localparam t_status ST_FIRED = 2'd3;

    localparam int DL_W  = 32;
    localparam int TAG_W = 16;
    localparam int PEND_W = 5;

    // One stored event
    typedef struct packed {
        logic [DL_W-1:0]  dl;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage
`default_nettype wire

// ===== hdl/sorted_deadline_event_queue.sv =====
`default_nettype none
// Results: an add into an empty queue, a full-queue drop, a tick with nothing due and a pop of
// the last entry strobe o_valid in the cycle after the transfer; an add that moves later
// entries steps through S_INS (and S_PLACE), a pop with more entries held through S_POP.
// Throughput: one item per result; busy is high while entries are moved and falls with the
// result strobe, set by the entry memory that moves one entry per cycle. No stall on output.
// Reset: synchronous active-low i_rst_n empties the queue; entry memory is not cleared.
module sorted_deadline_event_queue
    import sdeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_mode,
    input  wire logic [DL_W-1:0]   i_event_time,
    input  wire logic [TAG_W-1:0]  i_event_tag,
    input  wire logic [DL_W-1:0]   i_current_time,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [TAG_W-1:0]       o_fired_tag,
    output logic                   o_head_valid,
    output logic [DL_W-1:0]        o_next_deadline,
    output logic [PEND_W-1:0]      o_pending_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_PLACE,
        S_POP
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_idx, n_idx;
    t_entry             r_head, n_head;
    t_entry             r_new, n_new;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic [TAG_W-1:0]   r_fired, n_fired;
    logic               r_hvalid, n_hvalid;
    logic [DL_W-1:0]    r_next_dl, n_next_dl;
    logic [PEND_W-1:0]  r_pend, n_pend;

    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd_data;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    t_entry             w_wr_data;
    t_entry             w_in_entry;
    logic               w_fin;
    logic               w_due;
    logic [31:0]        w_cnt_ext;

    assign w_in_entry = '{dl: i_event_time, tag: i_event_tag};
    assign w_due      = (r_cnt != '0) && (r_head.dl <= i_current_time);
    assign w_cnt_ext  = 32'(n_cnt);

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Sequencer: insert scans down from the tail, pop shifts down from entry one
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_head    = r_head;
        n_new     = r_new;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_fired   = r_fired;
        n_hvalid  = r_hvalid;
        n_next_dl = r_next_dl;
        n_pend    = r_pend;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = r_new;
        w_fin     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!i_mode) begin
                        n_new   = w_in_entry;
                        n_fired = '0;
                        if (r_cnt == CW'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                            w_fin    = 1'b1;
                        end else if (r_cnt == '0) begin
                            n_status  = ST_ADDED;
                            w_wr_en   = 1'b1;
                            w_wr_data = w_in_entry;
                            n_head    = w_in_entry;
                            n_cnt     = CW'(1);
                            w_fin     = 1'b1;
                        end else begin
                            n_status  = ST_ADDED;
                            w_rd_addr = AW'(r_cnt - 1'b1);
                            n_idx     = AW'(r_cnt - 1'b1);
                            n_state   = S_INS;
                        end
                    end else if (w_due) begin
                        n_status = ST_FIRED;
                        n_fired  = r_head.tag;
                        if (r_cnt == CW'(1)) begin
                            n_cnt = '0;
                            w_fin = 1'b1;
                        end else begin
                            w_rd_addr = AW'(1);
                            n_idx     = AW'(1);
                            n_state   = S_POP;
                        end
                    end else begin
                        n_status = ST_IDLE;
                        n_fired  = '0;
                        w_fin    = 1'b1;
                    end
                end
            end
            S_INS: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(r_idx + 1'b1);
                if (r_rd_data.dl > r_new.dl) begin
                    // move the later entry up one place
                    w_wr_data = r_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        w_rd_addr = AW'(r_idx - 1'b1);
                        n_idx     = AW'(r_idx - 1'b1);
                    end
                end else begin
                    w_wr_data = r_new;
                    n_cnt     = CW'(r_cnt + 1'b1);
                    w_fin     = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_PLACE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                w_wr_data = r_new;
                n_head    = r_new;
                n_cnt     = CW'(r_cnt + 1'b1);
                w_fin     = 1'b1;
                n_state   = S_IDLE;
            end
            S_POP: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(r_idx - 1'b1);
                w_wr_data = r_rd_data;
                if (r_idx == AW'(1)) begin
                    n_head = r_rd_data;
                end
                if (CW'(CW'(r_idx) + 1'b1) == r_cnt) begin
                    n_cnt   = CW'(r_cnt - 1'b1);
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_rd_addr = AW'(r_idx + 1'b1);
                    n_idx     = AW'(r_idx + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Build the result from the updated queue
        if (w_fin) begin
            n_valid   = 1'b1;
            n_hvalid  = (n_cnt != '0);
            n_next_dl = (n_cnt != '0) ? n_head.dl : '0;
            n_pend    = w_cnt_ext[PEND_W-1:0];
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_idx     <= n_idx;
        r_head    <= n_head;
        r_new     <= n_new;
        r_status  <= n_status;
        r_fired   <= n_fired;
        r_hvalid  <= n_hvalid;
        r_next_dl <= n_next_dl;
        r_pend    <= n_pend;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_fired_tag     = r_fired;
    assign o_head_valid    = r_hvalid;
    assign o_next_deadline = r_next_dl;
    assign o_pending_count = r_pend;

endmodule
`default_nettype wire

// ===== hdl/sdeq_checker.sv =====
`default_nettype none
`include "sorted_deadline_event_queue_defines.svh"
module sdeq_checker
    import sdeq_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire logic [1:0]        o_status,
    input wire logic [TAG_W-1:0]  o_fired_tag,
    input wire logic              o_head_valid,
    input wire logic [DL_W-1:0]   o_next_deadline,
    input wire logic [PEND_W-1:0] o_pending_count
);

    logic w_empty_res;
    logic w_empty_clean;
    logic w_plain_res;
    logic w_full_res;

    assign w_empty_res   = o_valid && !o_head_valid;
    assign w_empty_clean = (o_next_deadline == '0) && (o_pending_count == '0);
    assign w_plain_res   = o_valid && (o_status != ST_FIRED);
    assign w_full_res    = o_valid && (o_status == ST_FULL);

    // A transfer either goes to work or answers at once
    `SDEQ_ASSERT_NEXT(a_xfer_progress, start && !busy, busy || o_valid, "transfer stalled")

    // An empty queue reports no deadline and no entries
    `SDEQ_ASSERT_NOW(a_empty_result, w_empty_res, w_empty_clean, "empty result not clean")

    // Only a fired result carries a tag
    `SDEQ_ASSERT_NOW(a_tag_zero, w_plain_res, o_fired_tag == '0, "stray fired tag")

    // A dropped add means the queue still holds entries
    `SDEQ_ASSERT_NOW(a_full_nonempty, w_full_res, o_head_valid, "full drop on empty queue")

endmodule

bind sorted_deadline_event_queue sdeq_checker u_sdeq_checker (.*);
`default_nettype wire
